// ===== hdl/npci_pkg.sv =====
// Shared types and constants for the nearest palette color index block.
// Holds the palette geometry, field widths, register and request codes, and the FSM type.
// No dependencies; the top level in hdl/ imports it, while npci_ram does not.
package npci_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    // field widths
    localparam int CHAN_W   = 8;
    localparam int ENTRY_W  = 3 * CHAN_W;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int COUNT_W  = 9;
    localparam int RESULT_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COUNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MODE  = 1'b1;
    localparam logic [COUNT_W-1:0]   COUNT_RESET     = 9'd256;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // fixed results
    localparam logic [RESULT_W-1:0] IDX_TRANSPARENT = 8'd0;
    localparam logic [RESULT_W-1:0] IDX_EMPTY       = 8'd1;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_FINISH
    } t_state;

    // sequencer controls
    typedef struct packed {
        logic in_ready;
        logic issue_en;
        logic drain_done;
        logic out_load;
    } t_ctrl;

endpackage

// ===== hdl/npci_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no package dependency.
module npci_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/nearest_palette_color_index_top.sv =====
// Top level of the nearest palette color index block: palette RAM, search sequencer,
// and one shared distance unit (three squares, a sum and a compare) over a short pipeline.
// Depends on npci_pkg and npci_ram.

// A load transfer writes one palette entry into the RAM and gives no result. A pixel
// transfer is searched one palette entry per cycle through a shared distance unit fed
// by the RAM read port over search range start..count-1, where start is 1 in alpha mode
// and 0 otherwise and count is color_count capped at the palette depth; its result then
// passes the drain and finish states into the output register. Transparent pixels and an
// empty range go from idle straight to the finish state, which loads the output register.
// The finish state waits while the output register is full until its result is taken.
// The input is not ready while a pixel is in work; the output register holds a finished
// index until it is taken, and the next item is accepted meanwhile. The palette has no
// reset; entries must be loaded before a search reads them.
module nearest_palette_color_index_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [7:0]                      i_entry_index,
    input  logic [npci_pkg::CHAN_W-1:0]     i_red,
    input  logic [npci_pkg::CHAN_W-1:0]     i_green,
    input  logic [npci_pkg::CHAN_W-1:0]     i_blue,
    input  logic [npci_pkg::CHAN_W-1:0]     i_alpha,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [npci_pkg::RESULT_W-1:0]   o_color_index,
    // configuration port
    input  logic                            i_cfg_we,
    input  logic [npci_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [npci_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import npci_pkg::*;

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [COUNT_W-1:0]  r_count;
    logic                r_alpha_mode;
    logic [CHAN_W-1:0]   r_red, r_green, r_blue;
    logic [CNT_W-1:0]    r_limit, r_issue;
    logic                r_p1_vld, r_p2_vld;
    logic [IDX_W-1:0]    r_p1_idx, r_p2_idx;
    logic [SQ_W-1:0]     r_sq_r, r_sq_g, r_sq_b;
    logic                r_have_best;
    logic [DIST_W-1:0]   r_best_dist;
    logic [IDX_W-1:0]    r_best_idx;
    logic [RESULT_W-1:0] r_result;
    logic                r_out_valid;
    logic [RESULT_W-1:0] r_color_index;

    logic                in_xfer, load_xfer, pixel_xfer;
    logic                transparent, range_empty, last_issue, out_free;
    logic                ram_we;
    logic [CNT_W-1:0]    limit, start;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [CHAN_W-1:0]   d_r, d_g, d_b;
    logic [DIST_W-1:0]   dist_sum;

    // transfer decode and search bounds
    always_comb begin
        in_xfer     = i_in_valid && ctrl.in_ready;
        load_xfer   = in_xfer && (i_req_type == REQ_LOAD);
        pixel_xfer  = in_xfer && (i_req_type == REQ_PIXEL);
        transparent = r_alpha_mode && (i_alpha == '0);
        limit       = (r_count > COUNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                          : CNT_W'(r_count);
        start       = CNT_W'(r_alpha_mode);
        range_empty = (start >= limit);
        last_issue  = ((r_issue + CNT_W'(1)) == r_limit);
        out_free    = !r_out_valid || i_out_ready;
        ram_we      = load_xfer && (9'(i_entry_index) < 9'(PALETTE_DEPTH));
    end

    // palette store
    npci_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_entry_index[IDX_W-1:0]),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pixel_xfer) begin
                    n_state = (transparent || range_empty) ? S_FINISH : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            S_IDLE:   ctrl.in_ready   = 1'b1;
            S_SEARCH: ctrl.issue_en   = 1'b1;
            S_DRAIN:  ctrl.drain_done = !r_p1_vld && !r_p2_vld;
            S_FINISH: ctrl.out_load   = out_free;
            default:  ctrl = '0;
        endcase
    end

    // shared distance unit, first half: absolute differences, squared in the payload registers
    always_comb begin
        d_r = (r_red >= ram_rdata[23:16]) ? r_red - ram_rdata[23:16]
                                          : ram_rdata[23:16] - r_red;
        d_g = (r_green >= ram_rdata[15:8]) ? r_green - ram_rdata[15:8]
                                           : ram_rdata[15:8] - r_green;
        d_b = (r_blue >= ram_rdata[7:0]) ? r_blue - ram_rdata[7:0]
                                         : ram_rdata[7:0] - r_blue;
    end

    // second half: sum of squares
    assign dist_sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= COUNT_RESET;
            r_alpha_mode <= 1'b0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_have_best  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COLOR_COUNT: r_count      <= i_cfg_data;
                    CFG_ALPHA_MODE:  r_alpha_mode <= i_cfg_data[0];
                    default:         r_count      <= r_count;
                endcase
            end

            // pipeline valid bits
            r_p1_vld <= ctrl.issue_en;
            r_p2_vld <= r_p1_vld;

            // best tracking
            if (pixel_xfer) begin
                r_have_best <= 1'b0;
            end else if (r_p2_vld) begin
                r_have_best <= 1'b1;
            end

            // output register
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // capture pixel and decide fixed results
        if (pixel_xfer) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_limit <= limit;
            r_issue <= start;
            if (transparent) begin
                r_result <= IDX_TRANSPARENT;
            end else begin
                r_result <= IDX_EMPTY;
            end
        end else if (ctrl.issue_en) begin
            r_issue <= r_issue + CNT_W'(1);
        end

        // pipeline index and squares
        r_p1_idx <= r_issue[IDX_W-1:0];
        r_p2_idx <= r_p1_idx;
        r_sq_r   <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g   <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b   <= SQ_W'(d_b) * SQ_W'(d_b);

        // compare, strict less keeps the lowest index on ties
        if (r_p2_vld && (!r_have_best || dist_sum < r_best_dist)) begin
            r_best_dist <= dist_sum;
            r_best_idx  <= r_p2_idx;
        end

        if (ctrl.drain_done) begin
            r_result <= RESULT_W'(r_best_idx);
        end

        if (ctrl.out_load) begin
            r_color_index <= r_result;
        end
    end

    assign o_in_ready    = ctrl.in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_color_index = r_color_index;

    // the chosen entry always lies below the limit of the search range
    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_best |-> (CNT_W'(r_best_idx) < r_limit))
        else $error("best index outside search range");

    // entries reach the compare stage in ascending order without gaps
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_vld && r_p2_vld) |-> (r_p1_idx == r_p2_idx + IDX_W'(1)))
        else $error("compare stage index out of order");

    // a pixel transfer always blocks the input on the next cycle
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_req_type == REQ_PIXEL) |=> !o_in_ready)
        else $error("input ready while pixel in work");

endmodule
